### hw/rtl/radix_integer_to_text_defines.svh
// Assertion macros shared by the radix_integer_to_text checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RADIX_INTEGER_TO_TEXT_DEFINES_SVH
`define RADIX_INTEGER_TO_TEXT_DEFINES_SVH

// clocked assertion, disabled while reset is asserted (active low)
`define RIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also checks across reset
`define RIT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rit_pkg.sv
// Package for the radix integer-to-text converter: widths, constants,
// register indexes, divider result type and symbol lookup.
// No dependencies.
`default_nettype none

package rit_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int STEP_BITS   = 8;
    localparam int N_CHUNK     = VALUE_WIDTH / STEP_BITS;
    localparam int CHUNK_W     = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
    localparam int RADIX_W     = 5;
    localparam int SYM_IDX_W   = $clog2(MAX_RADIX);
    localparam int SYM_SEL_W   = 4;
    localparam int NSYM_STORE  = 16;
    localparam int CHAR_W      = 8;
    localparam int SYMS_W      = NSYM_STORE * CHAR_W;
    localparam int DIG_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = DIG_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX  = 2'd0,
        REG_SYM_LO = 2'd1,
        REG_SYM_HI = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SYM_IDX_W-1:0] rem;
        logic [STEP_BITS-1:0] quo;
    } t_div_res;

    function automatic t_char sym_at(input logic [SYMS_W-1:0] syms,
                                     input logic [SYM_SEL_W-1:0] idx);
        return syms[{idx, 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/radix_integer_to_text.sv
// Radix integer-to-text converter, top level: config registers, sequencer,
// digit buffer, output register. Depends on rit_pkg, rit_symchk, rit_divstep.
//
// Usage:
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//    (0 radix length, 1 symbols 0..7, 2 symbols 8..15). Write only when idle.
//  - Input stream s_axis_*: one signed 32-bit value per transaction.
//  - Output stream m_axis_*: one character per transaction, tlast on the
//    final character. Invalid symbol set: the value is dropped, no output.
//  - Sequence: accept, check, then each digit via the shared 8-step divider,
//    one STEP_BITS chunk at a time over VALUE_WIDTH/8 = 4 chunks, then one
//    character per cycle ('-' first for negatives) while the receiver is
//    ready. s_axis_tready is high only while idle.
//  - Output is registered; a stalled receiver holds the sequencer in its
//    sign or emit step, the pending character stays stable until taken.
//  - Reset (i_rst_n low, synchronous): config cleared to 0, sequencer idle,
//    output empty.
`default_nettype none

module radix_integer_to_text
    import rit_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [VALUE_WIDTH-1:0] s_axis_tdata,   // [31:0] value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [CHAR_W-1:0]           m_axis_tdata,   // [7:0] character
    output logic                        m_axis_tlast
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_SIGN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(N_CHUNK - 1);

    t_state                 r_state, n_state;
    logic [RADIX_W-1:0]     r_radix;
    logic [CFG_DATA_W-1:0]  r_sym_lo, r_sym_hi;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [SYM_IDX_W-1:0]   r_rem, n_rem;
    logic [CHUNK_W-1:0]     r_chunk, n_chunk;
    logic [CNT_W-1:0]       r_ndig, n_ndig;
    logic                   r_ovalid, n_ovalid;
    t_char                  r_ochar, n_ochar;
    logic                   r_olast, n_olast;
    logic [SYM_IDX_W-1:0]   r_dig [VALUE_WIDTH];

    logic [SYMS_W-1:0]      w_syms;
    logic                   w_sym_ok;
    t_div_res               w_div;
    logic                   w_dig_we;
    logic                   w_slot_free;
    logic [CNT_W-1:0]       w_ndig_m1;

    assign w_syms = {r_sym_hi, r_sym_lo};

    rit_symchk u_symchk (
        .i_radix (r_radix),
        .i_syms  (w_syms),
        .o_ok    (w_sym_ok)
    );

    rit_divstep u_divstep (
        .i_radix (r_radix),
        .i_rem   (r_rem),
        .i_chunk (r_mag[VALUE_WIDTH-1 -: STEP_BITS]),
        .o_res   (w_div)
    );

    assign w_slot_free = !r_ovalid || m_axis_tready;
    assign w_ndig_m1   = r_ndig - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_chunk  = r_chunk;
        n_ndig   = r_ndig;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        w_dig_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mag   = s_axis_tdata;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_sym_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_neg   = r_mag[VALUE_WIDTH-1];
                    n_mag   = r_mag[VALUE_WIDTH-1] ? (~r_mag + VALUE_WIDTH'(1)) : r_mag;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_ndig  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_mag   = VALUE_WIDTH'({r_mag, w_div.quo});
                n_rem   = w_div.rem;
                n_chunk = r_chunk + CHUNK_W'(1);
                if (r_chunk == CHUNK_LAST) begin
                    w_dig_we = 1'b1;
                    n_ndig   = r_ndig + CNT_W'(1);
                    n_rem    = '0;
                    n_chunk  = '0;
                    if (n_mag == '0) begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = CH_MINUS;
                    n_olast  = 1'b0;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = sym_at(w_syms, SYM_SEL_W'(r_dig[w_ndig_m1[DIG_W-1:0]]));
                    n_olast  = (r_ndig == CNT_W'(1));
                    n_ndig   = w_ndig_m1;
                    if (r_ndig == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RADIX:  r_radix  <= i_cfg_data[RADIX_W-1:0];
                    REG_SYM_LO: r_sym_lo <= i_cfg_data;
                    REG_SYM_HI: r_sym_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_chunk <= n_chunk;
        r_ndig  <= n_ndig;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        if (w_dig_we) begin
            r_dig[r_ndig[DIG_W-1:0]] <= w_div.rem;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ochar;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

### hw/rtl/rit_symchk.sv
// Symbol set check: radix range, forbidden symbols and duplicate symbols.
// Depends on rit_pkg.
`default_nettype none

module rit_symchk
    import rit_pkg::*;
(
    input  wire logic [RADIX_W-1:0] i_radix,
    input  wire logic [SYMS_W-1:0]  i_syms,
    output logic                    o_ok
);

    logic  w_bad;
    t_char w_ci;

    always_comb begin
        w_bad = 1'b0;
        w_ci  = '0;
        if (int'(i_radix) < 2 || int'(i_radix) > MAX_RADIX) begin
            w_bad = 1'b1;
        end
        for (int i = 0; i < NSYM_STORE; i++) begin
            if (i < MAX_RADIX && i < int'(i_radix)) begin
                w_ci = sym_at(i_syms, SYM_SEL_W'(i));
                if (w_ci == '0 || w_ci == CH_PLUS || w_ci == CH_MINUS) begin
                    w_bad = 1'b1;
                end
                for (int j = i + 1; j < NSYM_STORE; j++) begin
                    if (j < MAX_RADIX && j < int'(i_radix)
                            && sym_at(i_syms, SYM_SEL_W'(j)) == w_ci) begin
                        w_bad = 1'b1;
                    end
                end
            end
        end
        o_ok = !w_bad;
    end

endmodule

`default_nettype wire

### hw/rtl/rit_divstep.sv
// Shared divider unit: STEP_BITS restoring steps of division by the radix,
// remainder in and out, one chunk of quotient bits out. Depends on rit_pkg.
`default_nettype none

module rit_divstep
    import rit_pkg::*;
(
    input  wire logic [RADIX_W-1:0]   i_radix,
    input  wire logic [SYM_IDX_W-1:0] i_rem,
    input  wire logic [STEP_BITS-1:0] i_chunk,
    output t_div_res                  o_res
);

    logic [RADIX_W:0]     w_t;
    logic [RADIX_W:0]     w_d;
    logic [SYM_IDX_W-1:0] w_rem;
    logic [STEP_BITS-1:0] w_q;

    always_comb begin
        w_rem = i_rem;
        w_q   = '0;
        w_t   = '0;
        w_d   = '0;
        for (int k = STEP_BITS - 1; k >= 0; k--) begin
            w_t = {{(RADIX_W - SYM_IDX_W){1'b0}}, w_rem, i_chunk[k]};
            w_d = w_t - {1'b0, i_radix};
            if (w_t >= {1'b0, i_radix}) begin
                w_q[k] = 1'b1;
                w_rem  = w_d[SYM_IDX_W-1:0];
            end else begin
                w_q[k] = 1'b0;
                w_rem  = w_t[SYM_IDX_W-1:0];
            end
        end
        o_res.rem = w_rem;
        o_res.quo = w_q;
    end

endmodule

`default_nettype wire

### hw/rtl/rit_checker.sv
// Port-level checker for radix_integer_to_text, bound to the top level.
// Depends on rit_pkg and radix_integer_to_text_defines.svh.
`default_nettype none
`include "radix_integer_to_text_defines.svh"

module rit_checker
    import rit_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [CHAR_W-1:0]      m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    logic            w_in_acc;
    logic            w_idle;
    logic            w_out_stall;
    logic [CHAR_W:0] w_out_word;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_idle      = s_axis_tready && !m_axis_tvalid;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_out_word  = {m_axis_tlast, m_axis_tdata};

    `RIT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> w_idle, "not idle after reset")
    `RIT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc |=> !s_axis_tready, "not busy")
    `RIT_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> m_axis_tvalid, "output valid dropped")
    `RIT_ASSERT(a_out_stable, i_clk, i_rst_n, w_out_stall |=> $stable(w_out_word), "data moved")

endmodule

bind radix_integer_to_text rit_checker u_rit_checker (.*);

`default_nettype wire
